/* hdl/epd_pkg.sv */
// Shared constants, register codes and types for the echo presence detector.
package epd_pkg;

	localparam int COUNT_BITS_DEF   = 16;
	localparam int CONFIRM_BITS_DEF = 3;

	localparam int WIDTH_W    = 16;
	localparam int DIST_W     = 11;
	localparam int LIMIT_W    = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_WAIT      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_LIMIT = 2'd3;

	localparam logic [WIDTH_W-1:0] MAX_WAIT_RST      = 16'd10000;
	localparam logic [WIDTH_W-1:0] MAX_WIDTH_RST     = 16'd36000;
	localparam logic [DIST_W-1:0]  NEAR_LIMIT_RST    = 11'd150;
	localparam logic [LIMIT_W-1:0] CONFIRM_LIMIT_RST = 3'd5;

	// microseconds per centimetre of range
	localparam int CM_DIVISOR = 58;
	localparam int REM_W      = 6;

	typedef struct packed {
		logic [WIDTH_W-1:0] max_wait;
		logic [WIDTH_W-1:0] max_width;
		logic [DIST_W-1:0]  near_limit;
		logic [LIMIT_W-1:0] confirm_limit;
	} cfg_t;

	typedef struct packed {
		logic               done;
		logic [WIDTH_W-1:0] width;
		logic [WIDTH_W-1:0] wait_time;
		logic               wait_to;
		logic               width_to;
		logic [DIST_W-1:0]  range_cm;
	} meas_t;

	typedef struct packed {
		logic [WIDTH_W-1:0] echo_width_us;
		logic [WIDTH_W-1:0] wait_time_us;
		logic               wait_timeout;
		logic               width_timeout;
		logic [DIST_W-1:0]  distance_cm;
		logic               near;
		logic [LIMIT_W-1:0] confirm_count;
		logic               present;
		logic               report;
	} res_t;

endpackage

/* hdl/epd_if.sv */
// Channel interfaces: input item, result and configuration write.
interface epd_item_if;
	logic valid;
	logic ready;
	logic req_type;
	logic echo_level;

	modport source (output valid, output req_type, output echo_level, input ready);
	modport sink (input valid, input req_type, input echo_level, output ready);
endinterface

interface epd_result_if;
	import epd_pkg::*;
	logic               valid;
	logic               ready;
	logic [WIDTH_W-1:0] echo_width_us;
	logic [WIDTH_W-1:0] wait_time_us;
	logic               wait_timeout;
	logic               width_timeout;
	logic [DIST_W-1:0]  distance_cm;
	logic               near;
	logic [LIMIT_W-1:0] confirm_count;
	logic               present;
	logic               report;

	modport source (output valid, output echo_width_us, output wait_time_us,
		output wait_timeout, output width_timeout, output distance_cm, output near,
		output confirm_count, output present, output report, input ready);
	modport sink (input valid, input echo_width_us, input wait_time_us,
		input wait_timeout, input width_timeout, input distance_cm, input near,
		input confirm_count, input present, input report, output ready);
endinterface

interface epd_cfg_if;
	import epd_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* hdl/epd_cfg_regs.sv */
// Configuration register bank.
module epd_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	epd_cfg_if.sink       cfg,
	output epd_pkg::cfg_t regs
);
	import epd_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.max_wait      <= MAX_WAIT_RST;
			regs_q.max_width     <= MAX_WIDTH_RST;
			regs_q.near_limit    <= NEAR_LIMIT_RST;
			regs_q.confirm_limit <= CONFIRM_LIMIT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_MAX_WAIT:      regs_q.max_wait      <= cfg.data;
				REG_MAX_WIDTH:     regs_q.max_width     <= cfg.data;
				REG_NEAR_LIMIT:    regs_q.near_limit    <= cfg.data[DIST_W-1:0];
				REG_CONFIRM_LIMIT: regs_q.confirm_limit <= cfg.data[LIMIT_W-1:0];
			endcase
		end
	end

endmodule

/* hdl/epd_measure.sv */
// Input register and echo wait/width timing with running centimetre count.
module epd_measure #(
	parameter int COUNT_BITS = epd_pkg::COUNT_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	epd_item_if.sink       item,
	input  epd_pkg::cfg_t  regs,
	input  logic           out_free,
	output epd_pkg::meas_t meas
);
	import epd_pkg::*;

	localparam int EXT_W = (COUNT_BITS > WIDTH_W) ? COUNT_BITS : WIDTH_W;
	localparam logic [REM_W-1:0] REM_LAST = REM_W'(CM_DIVISOR - 1);

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_WAIT  = 2'd1;
	localparam logic [1:0] PH_WIDTH = 2'd2;

	logic                  valid_s1;
	logic                  req_s1;
	logic                  level_s1;
	logic [1:0]            phase_q, phase_n;
	logic [COUNT_BITS-1:0] cnt_q, cnt_n, base_cnt, cnt_inc;
	logic [REM_W-1:0]      rem_q, rem_n, base_rem, rem_inc;
	logic [DIST_W-1:0]     quot_q, quot_n, base_quot, quot_inc;
	logic [WIDTH_W-1:0]    wait_hold_q, wait_hold_n;
	logic                  rising;
	logic                  wait_hit;
	logic                  width_hit;
	logic                  finish;
	logic                  adv;
	meas_t                 res;

	// rising edge restarts the count from zero
	assign rising    = (phase_q == PH_WAIT) && level_s1;
	assign base_cnt  = rising ? '0 : cnt_q;
	assign base_rem  = rising ? '0 : rem_q;
	assign base_quot = rising ? '0 : quot_q;

	always_comb begin
		cnt_inc  = base_cnt;
		rem_inc  = base_rem;
		quot_inc = base_quot;
		if (!(&base_cnt)) begin
			cnt_inc = base_cnt + 1'b1;
			if (base_rem == REM_LAST) begin
				rem_inc = '0;
				if (!(&base_quot))
					quot_inc = base_quot + 1'b1;
			end else begin
				rem_inc = base_rem + 1'b1;
			end
		end
	end

	assign wait_hit  = EXT_W'(cnt_inc) >= EXT_W'(regs.max_wait);
	assign width_hit = EXT_W'(cnt_inc) >= EXT_W'(regs.max_width);

	always_comb begin
		phase_n       = phase_q;
		cnt_n         = cnt_q;
		rem_n         = rem_q;
		quot_n        = quot_q;
		wait_hold_n   = wait_hold_q;
		finish        = 1'b0;
		res           = '0;
		res.width     = WIDTH_W'(EXT_W'(cnt_inc));
		res.wait_time = wait_hold_q;
		res.range_cm  = quot_inc;
		if (req_s1) begin
			phase_n     = PH_WAIT;
			cnt_n       = '0;
			rem_n       = '0;
			quot_n      = '0;
			wait_hold_n = '0;
		end else begin
			unique case (phase_q)
				PH_WAIT: begin
					cnt_n  = cnt_inc;
					rem_n  = rem_inc;
					quot_n = quot_inc;
					if (!level_s1) begin
						if (wait_hit) begin
							finish        = 1'b1;
							res.wait_to   = 1'b1;
							res.wait_time = WIDTH_W'(EXT_W'(cnt_inc));
							phase_n       = PH_IDLE;
						end
					end else begin
						wait_hold_n   = WIDTH_W'(EXT_W'(cnt_q));
						res.wait_time = WIDTH_W'(EXT_W'(cnt_q));
						phase_n       = PH_WIDTH;
						if (width_hit) begin
							finish       = 1'b1;
							res.width_to = 1'b1;
							phase_n      = PH_IDLE;
						end
					end
				end
				PH_WIDTH: begin
					if (level_s1) begin
						cnt_n  = cnt_inc;
						rem_n  = rem_inc;
						quot_n = quot_inc;
						if (width_hit) begin
							finish       = 1'b1;
							res.width_to = 1'b1;
							phase_n      = PH_IDLE;
						end
					end else begin
						finish       = 1'b1;
						res.width    = WIDTH_W'(EXT_W'(cnt_q));
						res.range_cm = quot_q;
						phase_n      = PH_IDLE;
					end
				end
				default: ;
			endcase
		end
	end

	// a word with no result moves on even while the output stalls
	assign adv        = valid_s1 && (!finish || out_free);
	assign item.ready = !valid_s1 || adv;

	always_comb begin
		meas      = res;
		meas.done = valid_s1 && finish && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			req_s1   <= item.req_type;
			level_s1 <= item.echo_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			cnt_q       <= '0;
			rem_q       <= '0;
			quot_q      <= '0;
			wait_hold_q <= '0;
		end else if (adv) begin
			phase_q     <= phase_n;
			cnt_q       <= cnt_n;
			rem_q       <= rem_n;
			quot_q      <= quot_n;
			wait_hold_q <= wait_hold_n;
		end
	end

	a_start_arms: assert property (@(posedge clk) disable iff (!arst_n)
		adv && req_s1 |=> phase_q == PH_WAIT && cnt_q == '0 && quot_q == '0)
		else $error("start did not arm a fresh measurement");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= REM_LAST)
		else $error("centimetre remainder out of range");

	a_width_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_WIDTH |-> cnt_q != '0)
		else $error("width phase with empty count");

endmodule

/* hdl/epd_confirm.sv */
// Near classification, presence confirmation and the result register.
module epd_confirm #(
	parameter int CONFIRM_BITS = epd_pkg::CONFIRM_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  epd_pkg::meas_t meas,
	input  epd_pkg::cfg_t  regs,
	epd_result_if.source   result,
	output logic           out_free
);
	import epd_pkg::*;

	localparam int CMP_W = (CONFIRM_BITS > LIMIT_W) ? CONFIRM_BITS : LIMIT_W;

	logic [CONFIRM_BITS-1:0] confirm_q, confirm_n;
	logic                    present_q, present_n;
	logic                    out_valid_q;
	res_t                    res_q;
	logic                    near;
	logic                    rep;
	logic [CMP_W-1:0]        lim;

	assign near = meas.range_cm <= regs.near_limit;
	assign lim  = CMP_W'(regs.confirm_limit);

	always_comb begin
		confirm_n = confirm_q;
		present_n = present_q;
		rep       = 1'b0;
		if (near) begin
			if ((CMP_W'(confirm_q) < lim) && !(&confirm_q)) begin
				confirm_n = confirm_q + 1'b1;
				if (CMP_W'(confirm_n) == lim) begin
					present_n = 1'b1;
					rep       = !present_q;
				end
			end
		end else if (confirm_q != '0) begin
			confirm_n = confirm_q - 1'b1;
			if (confirm_n == '0)
				present_n = 1'b0;
		end
	end

	assign out_free = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			confirm_q   <= '0;
			present_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free)
				out_valid_q <= meas.done;
			if (meas.done) begin
				confirm_q <= confirm_n;
				present_q <= present_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (meas.done) begin
			res_q.echo_width_us <= meas.width;
			res_q.wait_time_us  <= meas.wait_time;
			res_q.wait_timeout  <= meas.wait_to;
			res_q.width_timeout <= meas.width_to;
			res_q.distance_cm   <= meas.range_cm;
			res_q.near          <= near;
			res_q.confirm_count <= LIMIT_W'(CMP_W'(confirm_n));
			res_q.present       <= present_n;
			res_q.report        <= rep;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.echo_width_us = res_q.echo_width_us;
	assign result.wait_time_us  = res_q.wait_time_us;
	assign result.wait_timeout  = res_q.wait_timeout;
	assign result.width_timeout = res_q.width_timeout;
	assign result.distance_cm   = res_q.distance_cm;
	assign result.near          = res_q.near;
	assign result.confirm_count = res_q.confirm_count;
	assign result.present       = res_q.present;
	assign result.report        = res_q.report;

	a_report_present: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.report |-> result.present)
		else $error("report without presence");

	a_present_count: assert property (@(posedge clk) disable iff (!arst_n)
		present_q |-> confirm_q != '0)
		else $error("presence held with empty confirm counter");

	a_present_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(present_q) |-> $past(meas.done))
		else $error("presence set without a finished measurement");

endmodule

/* hdl/echo_presence_detector.sv */
// Top level of the ultrasonic echo presence detector.
//
// item channel: one word per microsecond tick carrying the sampled echo
// level, or a start word that arms a new measurement (dropping any running
// one). Ticks while no measurement is armed are ignored.
// result channel: one word per finished measurement with width, wait time,
// timeout flags, distance in cm, near flag and the presence state.
// cfg channel: register writes (wait limit, width limit, near limit,
// confirm limit), always ready; write only while no measurement runs.
// Throughput: one item word per cycle while no result is held up. The tick
// that ends a measurement enters the input register when accepted; its
// result word then goes to the result register once free. Distance is a
// running count beside the microsecond counter, so no divider is needed.
// Reset: registers take their default limits, measurement and presence
// state clear, no result is pending.
// A stalled receiver holds the result register; ticks that give no result
// keep flowing, and input ready drops only when a second result is due.
module echo_presence_detector #(
	parameter int COUNT_BITS   = epd_pkg::COUNT_BITS_DEF,
	parameter int CONFIRM_BITS = epd_pkg::CONFIRM_BITS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	epd_item_if.sink     item,
	epd_result_if.source result,
	epd_cfg_if.sink      cfg
);
	import epd_pkg::*;

	cfg_t  regs;
	meas_t meas;
	logic  out_free;

	epd_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	epd_measure #(
		.COUNT_BITS (COUNT_BITS)
	) u_measure (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.regs     (regs),
		.out_free (out_free),
		.meas     (meas)
	);

	epd_confirm #(
		.CONFIRM_BITS (CONFIRM_BITS)
	) u_confirm (
		.clk      (clk),
		.arst_n   (arst_n),
		.meas     (meas),
		.regs     (regs),
		.result   (result),
		.out_free (out_free)
	);

endmodule

/* test/echo_presence_detector_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for echo_presence_detector: directed and random echo words against a predictor.
module echo_presence_detector_tb;
	import epd_pkg::*;

	localparam bit REQ_TICK  = 1'b0;
	localparam bit REQ_START = 1'b1;
	localparam int SETTLE_CYCLES = 6;
	localparam int STALL_LIMIT   = 5000;
	localparam int REPORT_MAX    = 10;
	localparam int HOLD_CYCLES   = 400;

	typedef enum logic [1:0] {PH_IDLE, PH_WAIT, PH_WIDTH} echo_phase_t;

	class presence_scoreboard;
		cfg_t               regs;
		echo_phase_t        phase;
		logic [WIDTH_W-1:0] elapsed;
		logic [WIDTH_W-1:0] held;
		logic [WIDTH_W-1:0] wait_hold;
		bit                 wait_flag;
		logic [LIMIT_W-1:0] confirm;
		bit                 present;
		bit                 episode_reported;
		res_t               due_measurements[$];
		int                 failures;
		int                 shown;
		int                 produced;

		function new();
			regs.max_wait      = MAX_WAIT_RST;
			regs.max_width     = MAX_WIDTH_RST;
			regs.near_limit    = NEAR_LIMIT_RST;
			regs.confirm_limit = CONFIRM_LIMIT_RST;
			phase = PH_IDLE;
			elapsed = '0;
			held = '0;
			wait_hold = '0;
			wait_flag = 0;
			confirm = '0;
			present = 0;
			episode_reported = 0;
			failures = 0;
			shown = 0;
			produced = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
			case (idx)
				REG_MAX_WAIT:      regs.max_wait = d;
				REG_MAX_WIDTH:     regs.max_width = d;
				REG_NEAR_LIMIT:    regs.near_limit = d[DIST_W-1:0];
				REG_CONFIRM_LIMIT: regs.confirm_limit = d[LIMIT_W-1:0];
				default: ;
			endcase
		endfunction

		function void count_tick();
			if (elapsed != '1)
				elapsed++;
			held = elapsed;
		endfunction

		function void close_measurement(bit width_to);
			res_t r;
			int   d;
			bit   rep;
			d = held / CM_DIVISOR;
			if (d > 2047)
				d = 2047;
			rep = 0;
			r.distance_cm = DIST_W'(d);
			r.near = (r.distance_cm <= regs.near_limit);
			if (r.near) begin
				if (confirm < regs.confirm_limit && confirm != '1) begin
					confirm++;
					if (confirm == regs.confirm_limit) begin
						present = 1;
						if (!episode_reported) begin
							rep = 1;
							episode_reported = 1;
						end
					end
				end
			end else if (confirm != 0) begin
				confirm--;
				if (confirm == 0) begin
					present = 0;
					episode_reported = 0;
				end
			end
			r.echo_width_us = held;
			r.wait_time_us  = wait_hold;
			r.wait_timeout  = wait_flag;
			r.width_timeout = width_to;
			r.confirm_count = confirm;
			r.present       = present;
			r.report        = rep;
			due_measurements.push_back(r);
			produced++;
			phase = PH_IDLE;
		endfunction

		function void sample_word(bit start, bit level);
			if (start) begin
				phase = PH_WAIT;
				elapsed = '0;
				held = '0;
				wait_hold = '0;
				wait_flag = 0;
				return;
			end
			case (phase)
				PH_WAIT: begin
					if (!level) begin
						count_tick();
						if (elapsed >= regs.max_wait) begin
							wait_flag = 1;
							wait_hold = held;
							close_measurement(0);
						end
					end else begin
						// rising edge: this tick is the first microsecond of the width
						wait_hold = held;
						phase = PH_WIDTH;
						elapsed = '0;
						count_tick();
						if (elapsed >= regs.max_width)
							close_measurement(1);
					end
				end
				PH_WIDTH: begin
					if (level) begin
						count_tick();
						if (elapsed >= regs.max_width)
							close_measurement(1);
					end else begin
						close_measurement(0);
					end
				end
				default: ;
			endcase
		endfunction

		function void check_measurement(res_t got);
			res_t  exp;
			string diff;
			if (due_measurements.size() == 0) begin
				failures++;
				if (shown < REPORT_MAX)
					$display("unexpected result word %p", got);
				shown++;
				return;
			end
			exp = due_measurements.pop_front();
			diff = "";
			if (got.echo_width_us !== exp.echo_width_us) diff = {diff, " echo_width_us"};
			if (got.wait_time_us !== exp.wait_time_us)   diff = {diff, " wait_time_us"};
			if (got.wait_timeout !== exp.wait_timeout)   diff = {diff, " wait_timeout"};
			if (got.width_timeout !== exp.width_timeout) diff = {diff, " width_timeout"};
			if (got.distance_cm !== exp.distance_cm)     diff = {diff, " distance_cm"};
			if (got.near !== exp.near)                   diff = {diff, " near"};
			if (got.confirm_count !== exp.confirm_count) diff = {diff, " confirm_count"};
			if (got.present !== exp.present)             diff = {diff, " present"};
			if (got.report !== exp.report)               diff = {diff, " report"};
			if (diff != "") begin
				failures++;
				if (shown < REPORT_MAX)
					$display("mismatch in%s: expected %p, got %p", diff, exp, got);
				shown++;
			end
		endfunction

		function void close_out();
			if (due_measurements.size() != 0) begin
				failures += due_measurements.size();
				$display("%0d expected results never arrived", due_measurements.size());
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   send_idle;
	int   recv_idle;
	int   hold_left;
	int   words_counted;
	int   quiet;

	presence_scoreboard sb = new();

	epd_item_if   item_ch();
	epd_result_if res_ch();
	epd_cfg_if    cfg_ch();

	echo_presence_detector u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// result side: check, then decide ready for the next edge
	initial begin
		res_t got;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_ch.valid && res_ch.ready) begin
				got.echo_width_us = res_ch.echo_width_us;
				got.wait_time_us  = res_ch.wait_time_us;
				got.wait_timeout  = res_ch.wait_timeout;
				got.width_timeout = res_ch.width_timeout;
				got.distance_cm   = res_ch.distance_cm;
				got.near          = res_ch.near;
				got.confirm_count = res_ch.confirm_count;
				got.present       = res_ch.present;
				got.report        = res_ch.report;
				sb.check_measurement(got);
			end
			if (hold_left > 0) begin
				res_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	initial quiet = 0;
	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet <= 0;
		end else if (quiet >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic send_word(input bit req, input bit lvl);
		while ($urandom_range(99) < send_idle) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid      <= 1'b1;
		item_ch.req_type   <= req;
		item_ch.echo_level <= lvl;
		do @(posedge clk); while (!item_ch.ready);
		words_counted++;
		sb.sample_word(req, lvl);
	endtask

	task automatic send_run(input bit req, input bit lvl, input int n);
		repeat (n) send_word(req, lvl);
	endtask

	// close any open measurement, drain results, let the pipeline empty
	task automatic settle();
		if (sb.phase == PH_WAIT)
			send_word(REQ_TICK, 1'b1);
		if (sb.phase == PH_WIDTH)
			send_word(REQ_TICK, 1'b0);
		item_ch.valid <= 1'b0;
		while (sb.due_measurements.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_one(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= d;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.write_reg(idx, d);
	endtask

	task automatic set_config(input logic [WIDTH_W-1:0] wt, input logic [WIDTH_W-1:0] wd,
			input logic [DIST_W-1:0] nl, input logic [LIMIT_W-1:0] cl);
		settle();
		write_one(REG_MAX_WAIT, wt);
		write_one(REG_MAX_WIDTH, wd);
		write_one(REG_NEAR_LIMIT, CFG_DATA_W'(nl));
		write_one(REG_CONFIRM_LIMIT, CFG_DATA_W'(cl));
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic random_measurement();
		int pick;
		int wait_len;
		int width_len;
		pick = $urandom_range(99);
		if (pick < 8) begin
			repeat ($urandom_range(1, 4))
				send_word(1'($urandom_range(1)), 1'($urandom_range(1)));
			return;
		end
		wait_len = $urandom_range(0, 15);
		width_len = $urandom_range(1) ? $urandom_range(1, 20) : $urandom_range(50, 140);
		send_word(REQ_START, 1'($urandom_range(1)));
		send_run(REQ_TICK, 1'b0, wait_len);
		if (pick < 16) begin
			// broken echo: the next start drops it
			send_run(REQ_TICK, 1'b1, $urandom_range(0, width_len));
			return;
		end
		send_run(REQ_TICK, 1'b1, width_len);
		send_word(REQ_TICK, 1'b0);
	endtask

	initial begin
		int target_words;
		int target_results;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.req_type = REQ_TICK;
		item_ch.echo_level = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_MAX_WAIT;
		cfg_ch.data = '0;
		send_idle = 22;
		recv_idle = 62;
		hold_left = 0;
		words_counted = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ticks while idle, restart, normal echo, dropped measurement
		send_word(REQ_TICK, 1'b1);
		send_word(REQ_TICK, 1'b0);
		send_word(REQ_START, 1'b0);
		send_word(REQ_START, 1'b1);
		send_run(REQ_TICK, 1'b0, 3);
		send_run(REQ_TICK, 1'b1, 4);
		send_word(REQ_TICK, 1'b0);
		send_word(REQ_START, 1'b0);
		send_run(REQ_TICK, 1'b1, 2);
		send_word(REQ_START, 1'b0);
		send_word(REQ_TICK, 1'b1);
		send_word(REQ_TICK, 1'b0);

		// wait and width timeouts
		set_config(16'd3, 16'd4, 11'd0, 3'd1);
		send_word(REQ_START, 1'b0);
		send_run(REQ_TICK, 1'b0, 3);
		send_word(REQ_START, 1'b0);
		send_run(REQ_TICK, 1'b1, 4);

		// zero limits end on the first counted tick
		set_config(16'd0, 16'd0, 11'd0, 3'd0);
		send_word(REQ_START, 1'b0);
		send_word(REQ_TICK, 1'b0);
		send_word(REQ_START, 1'b0);
		send_word(REQ_TICK, 1'b1);

		for (int p = 0; p < 6; p++) begin
			if (p == 2) begin
				settle();
				send_idle = 62;
				recv_idle = 22;
			end
			if (p == 4) begin
				settle();
				send_idle = 0;
				recv_idle = 0;
			end
			case (p)
				0: set_config(16'd1, 16'd1, 11'd0, 3'd1);
				1: set_config('1, '1, 11'd1129, 3'd7);
				default: set_config(WIDTH_W'($urandom_range(2, 12)),
					WIDTH_W'($urandom_range(2, 150)), DIST_W'($urandom_range(0, 2)),
					LIMIT_W'($urandom_range(1, 7)));
			endcase
			target_words = words_counted + 100;
			target_results = sb.produced + 1;
			while (words_counted < target_words || sb.produced < target_results)
				random_measurement();
		end

		// receiver holds off while short echoes keep coming
		set_config(16'd20, 16'd20, 11'd0, 3'd3);
		hold_left = HOLD_CYCLES;
		repeat (20) begin
			send_word(REQ_START, 1'b0);
			send_run(REQ_TICK, 1'b1, $urandom_range(1, 3));
			send_word(REQ_TICK, 1'b0);
		end

		// widest limits, longer counts
		set_config('1, '1, 11'd1129, 3'd7);
		send_word(REQ_START, 1'b0);
		send_run(REQ_TICK, 1'b0, 3);
		send_run(REQ_TICK, 1'b1, 40);
		send_word(REQ_START, 1'b0);
		send_run(REQ_TICK, 1'b0, 40);

		settle();
		sb.close_out();
		if (sb.failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
